// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WOG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WOG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wog_pkg.sv =====
// ----------------------------------------------------------------------------
// wog_pkg
// types, codes and sizes shared by the occupancy grid modules
// ----------------------------------------------------------------------------
package wog_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // size registers and internal coordinates
  localparam int COORD_W = 9;
  // base plus signed offset
  localparam int SUM_W   = COORD_W + 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  localparam logic [COORD_W-1:0] SIZE_RESET = COORD_W'(256);

  // position of the skipped centre in the 3x3 scan
  localparam logic [3:0] CENTER_POS = 4'd4;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_WRAP_X      = 2'd2,
    CFG_WRAP_Y      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_PLACE     = 3'd0,
    MODE_OVERWRITE = 3'd1,
    MODE_CLEAR     = 3'd2,
    MODE_PROBE     = 3'd3,
    MODE_NBHD      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  // neighbour offset -1, 0, +1
  typedef enum logic [1:0] {
    D_MINUS = 2'd0,
    D_ZERO  = 2'd1,
    D_PLUS  = 2'd2
  } nbr_off_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RES,
    S_MOD,
    S_RD,
    S_CHK,
    S_NRD,
    S_NCK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [7:0]        base_x;
    logic [7:0]        base_y;
    logic signed [7:0] step_x;
    logic signed [7:0] step_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       was_occupied;
    logic [7:0] resolved_x;
    logic [7:0] resolved_y;
    logic [7:0] empty_mask;
    logic [7:0] occupied_mask;
  } out_item_t;

  // mask bit of neighbour (dx, dy), dx outer, centre skipped
  function automatic logic [2:0] mask_bit(input logic [1:0] dx, input logic [1:0] dy);
    logic [3:0] p;
    p = 4'(dx) * 4'd3 + 4'(dy);
    return (p > CENTER_POS) ? 3'(p - 4'd1) : 3'(p);
  endfunction

endpackage

// ===== hdl/wog_mod.sv =====
// ----------------------------------------------------------------------------
// wog_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module wog_mod import wog_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [COORD_W-1:0] divisor,
  output logic               done,
  output logic [COORD_W-1:0] remainder
);

  localparam int CNT_W = $clog2(COORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0] dvd_r;
  logic [COORD_W-1:0] dvs_r;
  logic [COORD_W-1:0] rem_r;
  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   diff;
  logic               fits;

  assign trial = {rem_r, dvd_r[COORD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/wrapping_occupancy_grid.sv =====
// ----------------------------------------------------------------------------
// wrapping_occupancy_grid
// occupancy bit map with wrapping or bounded axes and neighbour masks
// ----------------------------------------------------------------------------
// input channel in_valid/in_stall/in_data carries one command item: mode,
// base coordinate and signed offset; output channel out_valid/out_stall/
// out_data returns exactly one result item per command, in order
// cfg_we/cfg_index/cfg_data write the size and wrap registers; the user is
// to write them only while idle, and the block itself does not enforce this
// the map is one row-wide ram (one row per grid line) with a registered read;
// an in-range item reads its target row; place, overwrite and clear may then
// write it back; probe and neighbourhood items never write
// items are taken one at a time: in_stall is low only in the idle state
// neighbourhood items read up to three more rows; an axis wrapping past its
// size needs a remainder (9-step unit) first; a base out of range skips the ram
// the result sits in an output register; a stalled result holds the block in
// its last state, and the next item is taken once the register is loaded
// after reset a clearing pass writes zero to every row, with in_stall high;
// configuration writes are taken meanwhile
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrapping_occupancy_grid import wog_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // command items
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  // configuration writes
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] grid_width_r;
  logic [COORD_W-1:0] grid_height_r;
  logic               wrap_x_r;
  logic               wrap_y_r;
  logic [COORD_W-1:0] w_eff;
  logic [COORD_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIZE_RESET;
      grid_height_r <= SIZE_RESET;
      wrap_x_r      <= 1'b0;
      wrap_y_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        CFG_WRAP_X:      wrap_x_r      <= cfg_data[0];
        CFG_WRAP_Y:      wrap_y_r      <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the map size
  function automatic logic [COORD_W-1:0] eff_size(input logic [COORD_W-1:0] sz,
                                                  input int max_sz);
    logic [COORD_W-1:0] r;
    r = sz;
    if (sz == '0) begin
      r = COORD_W'(1);
    end else if (int'(sz) > max_sz) begin
      r = COORD_W'(max_sz);
    end
    return r;
  endfunction

  assign w_eff = eff_size(grid_width_r, MAX_WIDTH);
  assign h_eff = eff_size(grid_height_r, MAX_HEIGHT);

  // --------------------------------------------------------------------------
  // coordinate resolution
  // --------------------------------------------------------------------------
  // wrapping axis: negative gets size added once then floors at 0,
  // at or past size takes the remainder; bounded axis keeps base when outside
  function automatic logic [COORD_W-1:0] resolve(input logic [7:0]             base,
                                                 input logic signed [SUM_W-1:0] sum,
                                                 input logic [COORD_W-1:0]     size,
                                                 input logic                   wrap,
                                                 input logic [COORD_W-1:0]     modres);
    logic signed [SUM_W:0] t;
    logic [COORD_W-1:0]    r;
    t = $signed({sum[SUM_W-1], sum}) + $signed({2'b00, size});
    if (sum < 0) begin
      if (wrap) begin
        r = (t < 0) ? '0 : t[COORD_W-1:0];
      end else begin
        r = COORD_W'(base);
      end
    end else if (sum >= $signed({1'b0, size})) begin
      r = wrap ? modres : COORD_W'(base);
    end else begin
      r = sum[COORD_W-1:0];
    end
    return r;
  endfunction

  // neighbour of c one step away: {in grid, coordinate}
  function automatic logic [COORD_W:0] nbr_coord(input logic [COORD_W-1:0] c,
                                                 input nbr_off_e           d,
                                                 input logic [COORD_W-1:0] size,
                                                 input logic               wrap);
    logic [COORD_W:0] r;
    case (d)
      D_MINUS: r = (c == '0) ? {wrap, size - 1'b1} : {1'b1, c - 1'b1};
      D_PLUS:  r = (({1'b0, c} + 1'b1) >= {1'b0, size}) ? {wrap, {COORD_W{1'b0}}}
                                                        : {1'b1, c + 1'b1};
      default: r = {1'b1, c};
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // item registers and datapath
  // --------------------------------------------------------------------------
  state_e                    state_r, state_nxt;
  in_item_t                  item_r;
  logic [ROW_W-1:0]          clr_cnt_r;
  nbr_off_e                  nbr_cnt_r;
  logic [COORD_W-1:0]        rx_r;
  logic [COORD_W-1:0]        ry_r;
  logic [1:0]                status_r;
  logic                      was_r;
  logic [7:0]                emask_r;
  logic [7:0]                omask_r;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r;

  logic                      in_accept;
  logic                      out_free;
  logic                      clr_last;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic                      in_range;
  logic                      need_mod_x;
  logic                      need_mod_y;
  logic                      mod_start;
  logic                      mx_done;
  logic                      my_done;
  logic [COORD_W-1:0]        mx_rem;
  logic [COORD_W-1:0]        my_rem;
  logic                      res_load;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign clr_last  = clr_cnt_r == ROW_W'(MAX_HEIGHT - 1);

  assign sum_x = $signed({2'b00, item_r.base_x}) + $signed({{2{item_r.step_x[7]}}, item_r.step_x});
  assign sum_y = $signed({2'b00, item_r.base_y}) + $signed({{2{item_r.step_y[7]}}, item_r.step_y});

  assign in_range   = ({1'b0, item_r.base_x} < w_eff) && ({1'b0, item_r.base_y} < h_eff);
  assign need_mod_x = wrap_x_r && (sum_x >= $signed({1'b0, w_eff}));
  assign need_mod_y = wrap_y_r && (sum_y >= $signed({1'b0, h_eff}));

  // both axes run together so they finish in the same cycle
  wog_mod u_mod_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (sum_x[COORD_W-1:0]),
    .divisor   (w_eff),
    .done      (mx_done),
    .remainder (mx_rem)
  );

  wog_mod u_mod_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (sum_y[COORD_W-1:0]),
    .divisor   (h_eff),
    .done      (my_done),
    .remainder (my_rem)
  );

  // --------------------------------------------------------------------------
  // occupancy ram, one row per grid line
  // --------------------------------------------------------------------------
  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data_r;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic [MAX_WIDTH-1:0] row_upd;
  logic [ROW_W-1:0]     mem_addr;
  logic                 mem_we;
  logic                 mem_re;
  logic                 cur_bit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // occupancy of the target before this item
  assign cur_bit = rd_data_r[COL_W'(rx_r)];

  always_comb begin
    row_upd                = rd_data_r;
    row_upd[COL_W'(rx_r)]  = (item_r.mode != MODE_CLEAR);
  end

  // --------------------------------------------------------------------------
  // neighbour scan of the row just read
  // --------------------------------------------------------------------------
  logic [COORD_W:0] col_n [3];
  logic [COORD_W:0] row_n;
  logic [7:0]       nbr_emask;
  logic [7:0]       nbr_omask;

  assign row_n = nbr_coord(ry_r, nbr_cnt_r, h_eff, wrap_y_r);

  always_comb begin
    logic [2:0] bidx;
    bidx      = '0;
    nbr_emask = '0;
    nbr_omask = '0;
    for (int dx = 0; dx < 3; dx++) begin
      col_n[dx] = nbr_coord(rx_r, nbr_off_e'(2'(dx)), w_eff, wrap_x_r);
      if (row_n[COORD_W] && col_n[dx][COORD_W] &&
          !(nbr_off_e'(2'(dx)) == D_ZERO && nbr_cnt_r == D_ZERO)) begin
        bidx = mask_bit(2'(dx), nbr_cnt_r);
        if (rd_data_r[COL_W'(col_n[dx][COORD_W-1:0])]) begin
          nbr_omask[bidx] = 1'b1;
        end else begin
          nbr_emask[bidx] = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_accept) state_nxt = S_RES;
      S_RES: begin
        if (!in_range) begin
          state_nxt = S_OUT;
        end else if (need_mod_x || need_mod_y) begin
          state_nxt = S_MOD;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_MOD:   if (mx_done) state_nxt = S_RD;
      S_RD:    state_nxt = S_CHK;
      S_CHK:   state_nxt = (item_r.mode == MODE_NBHD) ? S_NRD : S_OUT;
      S_NRD:   state_nxt = S_NCK;
      S_NCK:   if (nbr_cnt_r == D_PLUS) state_nxt = S_OUT;
               else state_nxt = S_NRD;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: per-state controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = ROW_W'(ry_r);
    mem_wdata = row_upd;
    mod_start = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      S_IDLE:  in_stall = 1'b0;
      S_RES: begin
        mod_start = in_range && (need_mod_x || need_mod_y);
        res_load  = in_range && !(need_mod_x || need_mod_y);
      end
      S_MOD:   res_load = mx_done;
      S_RD:    mem_re = 1'b1;
      S_CHK: begin
        case (item_r.mode)
          MODE_PLACE:     mem_we = !cur_bit;
          MODE_OVERWRITE: mem_we = 1'b1;
          MODE_CLEAR:     mem_we = cur_bit;
          default:        mem_we = 1'b0;
        endcase
      end
      S_NRD: begin
        mem_re   = row_n[COORD_W];
        mem_addr = ROW_W'(row_n[COORD_W-1:0]);
      end
      default: ;
    endcase
  end

  // output register: loaded on the way out, emptied when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_OUT && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // item and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (state_r == S_RES) begin
      status_r <= in_range ? ST_OK : ST_RANGE;
      was_r    <= 1'b0;
      emask_r  <= '0;
      omask_r  <= '0;
      // out-of-range base is reported as is
      rx_r     <= COORD_W'(item_r.base_x);
      ry_r     <= COORD_W'(item_r.base_y);
    end
    if (res_load) begin
      rx_r <= resolve(item_r.base_x, sum_x, w_eff, wrap_x_r, mx_rem);
      ry_r <= resolve(item_r.base_y, sum_y, h_eff, wrap_y_r, my_rem);
    end
    if (state_r == S_CHK) begin
      was_r     <= cur_bit;
      nbr_cnt_r <= D_MINUS;
      case (item_r.mode)
        MODE_PLACE: if (cur_bit) status_r <= ST_OCCUPIED;
        MODE_CLEAR: if (!cur_bit) status_r <= ST_EMPTY;
        default:    ;
      endcase
    end
    if (state_r == S_NCK) begin
      emask_r <= emask_r | nbr_emask;
      omask_r <= omask_r | nbr_omask;
      case (nbr_cnt_r)
        D_MINUS: nbr_cnt_r <= D_ZERO;
        D_ZERO:  nbr_cnt_r <= D_PLUS;
        default: nbr_cnt_r <= D_PLUS;
      endcase
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r.status        <= status_r;
      out_data_r.was_occupied  <= was_r;
      out_data_r.resolved_x    <= rx_r[7:0];
      out_data_r.resolved_y    <= ry_r[7:0];
      out_data_r.empty_mask    <= emask_r;
      out_data_r.occupied_mask <= omask_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `WOG_ASSERT_IMPLY(a_write_phase, mem_we, state_r == S_CLEAR || state_r == S_CHK,
                    "ram written outside clear or check")
  `WOG_ASSERT_IMPLY(a_nbhd_read_only, state_r == S_CHK && item_r.mode == MODE_NBHD, !mem_we,
                    "neighbourhood item wrote the ram")
  `WOG_ASSERT_IMPLY(a_target_in_grid, state_r == S_RD, rx_r < w_eff && ry_r < h_eff,
                    "resolved target outside the grid")
  `WOG_ASSERT_IMPLY(a_mod_lockstep, mx_done, my_done && mx_rem < w_eff && my_rem < h_eff,
                    "remainder units out of step or out of bound")
  `WOG_ASSERT_NEXT(a_result_loaded, state_r == S_OUT && out_free,
                   out_valid_r && state_r == S_IDLE, "result not loaded on exit")

endmodule
